// ===== design/y2r_pkg.sv =====
// Shared types and constants for the YUYV 4:2:2 to RGB888 converter.
// No dependencies; every other design file imports this package.
`default_nettype none

package y2r_pkg;

	// Field widths.
	localparam int COEF_W  = 17;
	localparam int BYTE_W  = 8;
	localparam int DIFF_W  = 9;
	localparam int PROD_W  = COEF_W + 1 + DIFF_W;
	localparam int INDEX_W = 2;

	// Offset removed from the chroma bytes and the top of a color channel.
	localparam logic [BYTE_W-1:0] CHROMA_OFFSET = 8'd128;
	localparam logic [BYTE_W-1:0] CHAN_MAX      = 8'd255;

	// Configuration register indexes.
	localparam logic [INDEX_W-1:0] REG_V_TO_RED   = 2'd0;
	localparam logic [INDEX_W-1:0] REG_V_TO_GREEN = 2'd1;
	localparam logic [INDEX_W-1:0] REG_U_TO_GREEN = 2'd2;
	localparam logic [INDEX_W-1:0] REG_U_TO_BLUE  = 2'd3;

	// Default gains in millionths; scaled to the fraction width at elaboration.
	localparam longint unsigned MICRO_V_TO_RED   = 64'd1370705;
	localparam longint unsigned MICRO_V_TO_GREEN = 64'd698001;
	localparam longint unsigned MICRO_U_TO_GREEN = 64'd337633;
	localparam longint unsigned MICRO_U_TO_BLUE  = 64'd1732446;
	localparam longint unsigned MICRO_SCALE      = 64'd1000000;
	localparam longint unsigned MICRO_HALF       = 64'd500000;

	// The four gain registers.
	typedef struct packed {
		logic [COEF_W-1:0] v_to_red;
		logic [COEF_W-1:0] v_to_green;
		logic [COEF_W-1:0] u_to_green;
		logic [COEF_W-1:0] u_to_blue;
	} coef_t;

	// Chroma products shared by both pixels of a pair.
	typedef struct packed {
		logic signed [PROD_W-1:0] v_to_red;
		logic signed [PROD_W-1:0] v_to_green;
		logic signed [PROD_W-1:0] u_to_green;
		logic signed [PROD_W-1:0] u_to_blue;
	} prod_t;

	// One RGB888 pixel.
	typedef struct packed {
		logic [BYTE_W-1:0] red;
		logic [BYTE_W-1:0] green;
		logic [BYTE_W-1:0] blue;
	} rgb_t;

endpackage

`default_nettype wire

// ===== design/y2r_if.sv =====
// Valid/ready channel interfaces for the macropixel input and the RGB pair output.
// Depends on y2r_pkg for the field widths.
`default_nettype none

interface y2r_pix_if import y2r_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] luma_first;
	logic [BYTE_W-1:0] chroma_blue;
	logic [BYTE_W-1:0] luma_second;
	logic [BYTE_W-1:0] chroma_red;
	logic              end_of_frame;

	modport source (output valid, luma_first, chroma_blue, luma_second, chroma_red,
		end_of_frame, input ready);
	modport sink (input valid, luma_first, chroma_blue, luma_second, chroma_red,
		end_of_frame, output ready);
endinterface

interface y2r_rgb_if import y2r_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] red_first;
	logic [BYTE_W-1:0] green_first;
	logic [BYTE_W-1:0] blue_first;
	logic [BYTE_W-1:0] red_second;
	logic [BYTE_W-1:0] green_second;
	logic [BYTE_W-1:0] blue_second;
	logic              frame_done;

	modport source (output valid, red_first, green_first, blue_first, red_second,
		green_second, blue_second, frame_done, input ready);
	modport sink (input valid, red_first, green_first, blue_first, red_second,
		green_second, blue_second, frame_done, output ready);
endinterface

`default_nettype wire

// ===== design/y2r_coef_regs.sv =====
// Gain register file written through the plain configuration port.
// Depends on y2r_pkg; reset values follow the fraction width parameter.
`default_nettype none

module y2r_coef_regs import y2r_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               wr_en,
	input  wire logic [INDEX_W-1:0] wr_index,
	input  wire logic [COEF_W-1:0]  wr_data,
	output coef_t                   coefs
);

	// Round the decimal gains to the fixed point format, keep 17 bits.
	localparam logic [63:0] RST_VR_FULL =
		((MICRO_V_TO_RED << FRAC_BITS) + MICRO_HALF) / MICRO_SCALE;
	localparam logic [63:0] RST_VG_FULL =
		((MICRO_V_TO_GREEN << FRAC_BITS) + MICRO_HALF) / MICRO_SCALE;
	localparam logic [63:0] RST_UG_FULL =
		((MICRO_U_TO_GREEN << FRAC_BITS) + MICRO_HALF) / MICRO_SCALE;
	localparam logic [63:0] RST_UB_FULL =
		((MICRO_U_TO_BLUE << FRAC_BITS) + MICRO_HALF) / MICRO_SCALE;

	coef_t coefs_q;

	// One register per index; writes take effect at the next edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coefs_q.v_to_red   <= RST_VR_FULL[COEF_W-1:0];
			coefs_q.v_to_green <= RST_VG_FULL[COEF_W-1:0];
			coefs_q.u_to_green <= RST_UG_FULL[COEF_W-1:0];
			coefs_q.u_to_blue  <= RST_UB_FULL[COEF_W-1:0];
		end else if (wr_en) begin
			case (wr_index)
				REG_V_TO_RED:   coefs_q.v_to_red   <= wr_data;
				REG_V_TO_GREEN: coefs_q.v_to_green <= wr_data;
				REG_U_TO_GREEN: coefs_q.u_to_green <= wr_data;
				REG_U_TO_BLUE:  coefs_q.u_to_blue  <= wr_data;
				default: ;
			endcase
		end
	end

	assign coefs = coefs_q;

endmodule

`default_nettype wire

// ===== design/y2r_chroma_mult.sv =====
// First pipeline stage: the four chroma products, registered.
// Depends on y2r_pkg. Both pixel lanes share these products.
`default_nettype none

module y2r_chroma_mult import y2r_pkg::*; (
	input  wire logic              clk,
	input  wire logic              advance,
	input  wire logic [BYTE_W-1:0] chroma_blue,
	input  wire logic [BYTE_W-1:0] chroma_red,
	input  wire coef_t             coefs,
	output prod_t                  prods_s1
);

	logic signed [DIFF_W-1:0] du;
	logic signed [DIFF_W-1:0] dv;
	prod_t prods;

	// Removing the offset of 128 is an inversion of the top bit, sign extended.
	assign du = DIFF_W'(signed'({~chroma_blue[BYTE_W-1], chroma_blue[BYTE_W-2:0]}));
	assign dv = DIFF_W'(signed'({~chroma_red[BYTE_W-1], chroma_red[BYTE_W-2:0]}));

	// Unsigned gains times signed differences, one multiplier each.
	always_comb begin
		prods.v_to_red   = PROD_W'(signed'({1'b0, coefs.v_to_red}) * dv);
		prods.v_to_green = PROD_W'(signed'({1'b0, coefs.v_to_green}) * dv);
		prods.u_to_green = PROD_W'(signed'({1'b0, coefs.u_to_green}) * du);
		prods.u_to_blue  = PROD_W'(signed'({1'b0, coefs.u_to_blue}) * du);
	end

	// Product register; payload only, no reset.
	always_ff @(posedge clk) begin
		if (advance) begin
			prods_s1 <= prods;
		end
	end

endmodule

`default_nettype wire

// ===== design/y2r_pixel_lane.sv =====
// One pixel lane: adds the scaled luma to the chroma products and clamps.
// Depends on y2r_pkg. The top level instantiates two of these.
`default_nettype none

module y2r_pixel_lane import y2r_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic [BYTE_W-1:0] luma,
	input  wire prod_t             prods,
	output rgb_t                   pixel
);

	// Wide enough for the scaled luma plus two products with margin.
	localparam int BASE_W = FRAC_BITS + BYTE_W;
	localparam int ACC_W  = ((BASE_W > PROD_W) ? BASE_W : PROD_W) + 2;

	logic signed [ACC_W-1:0] base;
	logic signed [ACC_W-1:0] acc_red;
	logic signed [ACC_W-1:0] acc_green;
	logic signed [ACC_W-1:0] acc_blue;

	// Floor by an arithmetic shift, then saturate to a byte.
	function automatic logic [BYTE_W-1:0] clamp_chan(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] whole;
		whole = acc >>> FRAC_BITS;
		if (acc[ACC_W-1]) begin
			return '0;
		end else if (whole > signed'(ACC_W'(CHAN_MAX))) begin
			return CHAN_MAX;
		end else begin
			return whole[BYTE_W-1:0];
		end
	endfunction

	assign base = signed'(ACC_W'({luma, {FRAC_BITS{1'b0}}}));

	// Channel sums.
	assign acc_red   = base + ACC_W'(prods.v_to_red);
	assign acc_green = base - ACC_W'(prods.v_to_green) - ACC_W'(prods.u_to_green);
	assign acc_blue  = base + ACC_W'(prods.u_to_blue);

	assign pixel.red   = clamp_chan(acc_red);
	assign pixel.green = clamp_chan(acc_green);
	assign pixel.blue  = clamp_chan(acc_blue);

endmodule

`default_nettype wire

// ===== design/yuyv_to_rgb24_converter.sv =====
// YUYV 4:2:2 to RGB888 converter, top level.
// Input channel pix carries one macropixel per transfer (Y0, U, Y1, V and an
// end-of-frame mark); output channel rgb carries the two RGB888 pixels that
// share that chroma pair, with the mark copied to frame_done.
// An input transfer passes through one stage of four chroma multipliers,
// then two pixel lanes that add the luma, floor and clamp into the output
// register on rgb. One macropixel is taken every cycle unless a result is
// stalled at rgb; the multiplier stage and both lanes are fully pipelined.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and pix.ready drops; it rises again in the cycle the result is taken.
// The user must write gain registers via wr_en, wr_index and wr_data only
// while the block is idle, unenforced by the block. Reset loads the default
// gains rounded to COEF_FRAC_BITS fraction bits and empties the pipeline.
// Depends on y2r_pkg, y2r_if, y2r_coef_regs, y2r_chroma_mult, y2r_pixel_lane.
`default_nettype none

module yuyv_to_rgb24_converter import y2r_pkg::*; #(
	parameter int COEF_FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               wr_en,
	input  wire logic [INDEX_W-1:0] wr_index,
	input  wire logic [COEF_W-1:0]  wr_data,
	y2r_pix_if.sink                 pix,
	y2r_rgb_if.source               rgb
);

	coef_t             coefs;
	prod_t             prods_s1;
	logic              advance;
	logic              vld_s1;
	logic [BYTE_W-1:0] luma_first_s1;
	logic [BYTE_W-1:0] luma_second_s1;
	logic              eof_s1;
	rgb_t              pixel_first;
	rgb_t              pixel_second;
	logic              vld_s2;
	rgb_t              pixel_first_s2;
	rgb_t              pixel_second_s2;
	logic              eof_s2;

	// The pipeline moves unless a finished result is waiting on the receiver.
	assign advance   = !vld_s2 || rgb.ready;
	assign pix.ready = advance;

	y2r_coef_regs #(
		.FRAC_BITS(COEF_FRAC_BITS)
	) u_coef_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_index(wr_index),
		.wr_data (wr_data),
		.coefs   (coefs)
	);

	y2r_chroma_mult u_chroma_mult (
		.clk        (clk),
		.advance    (advance),
		.chroma_blue(pix.chroma_blue),
		.chroma_red (pix.chroma_red),
		.coefs      (coefs),
		.prods_s1   (prods_s1)
	);

	// Stage 1 control and the fields that travel alongside the products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			luma_first_s1  <= pix.luma_first;
			luma_second_s1 <= pix.luma_second;
			eof_s1         <= pix.end_of_frame;
		end
	end

	// Two lanes, one per pixel of the pair.
	y2r_pixel_lane #(
		.FRAC_BITS(COEF_FRAC_BITS)
	) u_lane_first (
		.luma (luma_first_s1),
		.prods(prods_s1),
		.pixel(pixel_first)
	);

	y2r_pixel_lane #(
		.FRAC_BITS(COEF_FRAC_BITS)
	) u_lane_second (
		.luma (luma_second_s1),
		.prods(prods_s1),
		.pixel(pixel_second)
	);

	// Merge stage: both lanes and the frame mark land in the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pixel_first_s2  <= pixel_first;
			pixel_second_s2 <= pixel_second;
			eof_s2          <= eof_s1;
		end
	end

	assign rgb.valid        = vld_s2;
	assign rgb.red_first    = pixel_first_s2.red;
	assign rgb.green_first  = pixel_first_s2.green;
	assign rgb.blue_first   = pixel_first_s2.blue;
	assign rgb.red_second   = pixel_second_s2.red;
	assign rgb.green_second = pixel_second_s2.green;
	assign rgb.blue_second  = pixel_second_s2.blue;
	assign rgb.frame_done   = eof_s2;

	// A waiting result must block new input.
	assert property (@(posedge clk) disable iff (!arst_n)
		rgb.valid && !rgb.ready |-> !pix.ready)
		else $error("input accepted while a result is stalled");

	// An accepted macropixel occupies the first stage on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid && pix.ready |=> vld_s1)
		else $error("accepted macropixel lost before the first stage");

	// An item in the first stage reaches the output when the pipeline moves.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && vld_s1 |=> rgb.valid)
		else $error("first stage item did not reach the output register");

	// A write to the red gain is seen on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && wr_index == REG_V_TO_RED |=> coefs.v_to_red == $past(wr_data))
		else $error("red gain write not applied");

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the YUYV 4:2:2 to RGB888 converter.
// Depends on y2r_pkg, the pix and rgb channel interfaces and the converter top level.
// Drives directed and random macropixels under several gain settings and checks each pair.
`default_nettype none

module tb_top;
	import y2r_pkg::*;

	localparam int FRAC           = 16;
	localparam int PIPE_LAT       = 2;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int RANDOM_PER_SET = 75;
	localparam logic [COEF_W-1:0] GAIN_MAX = 17'd131071;

	// Gains loaded by reset: the default decimals scaled to Q16.
	localparam coef_t GAINS_DEFAULT = '{v_to_red: 17'd89831, v_to_green: 17'd45744,
		u_to_green: 17'd22127, u_to_blue: 17'd113538};

	typedef enum {GAINS_MAX, GAINS_ZERO, GAINS_RANDOM, GAINS_MIXED, GAINS_RESTORE} gain_set_t;

	// One packed macropixel as it goes into the block.
	typedef struct packed {
		logic [BYTE_W-1:0] y0;
		logic [BYTE_W-1:0] u;
		logic [BYTE_W-1:0] y1;
		logic [BYTE_W-1:0] v;
		logic              eof;
	} macropixel_t;

	// The two pixels and the frame mark that one macropixel yields.
	typedef struct packed {
		rgb_t first;
		rgb_t second;
		logic done;
	} pixel_pair_t;

	typedef struct packed {
		macropixel_t px;
		logic        typed;
		pixel_pair_t want;
	} stim_row_t;

	// Directed rows; typed rows carry neutral chroma, so the pixels are plain gray.
	localparam int N_DIRECTED = 15;
	localparam stim_row_t DIRECTED [N_DIRECTED] = '{
		'{'{8'd0, 8'd128, 8'd255, 8'd128, 1'b0}, 1'b1,
			'{'{8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255}, 1'b0}},
		'{'{8'd255, 8'd128, 8'd0, 8'd128, 1'b1}, 1'b1,
			'{'{8'd255, 8'd255, 8'd255}, '{8'd0, 8'd0, 8'd0}, 1'b1}},
		'{'{8'd128, 8'd128, 8'd1, 8'd128, 1'b0}, 1'b1,
			'{'{8'd128, 8'd128, 8'd128}, '{8'd1, 8'd1, 8'd1}, 1'b0}},
		'{'{8'd0, 8'd0, 8'd0, 8'd0, 1'b0}, 1'b0, '0},
		'{'{8'd255, 8'd255, 8'd255, 8'd255, 1'b0}, 1'b0, '0},
		'{'{8'd0, 8'd255, 8'd0, 8'd255, 1'b0}, 1'b0, '0},
		'{'{8'd255, 8'd0, 8'd255, 8'd0, 1'b1}, 1'b0, '0},
		'{'{8'd16, 8'd255, 8'd235, 8'd0, 1'b0}, 1'b0, '0},
		'{'{8'd235, 8'd0, 8'd16, 8'd255, 1'b1}, 1'b0, '0},
		'{'{8'd128, 8'd127, 8'd128, 8'd129, 1'b0}, 1'b0, '0},
		'{'{8'd128, 8'd129, 8'd128, 8'd127, 1'b0}, 1'b0, '0},
		'{'{8'd0, 8'd255, 8'd255, 8'd0, 1'b0}, 1'b0, '0},
		'{'{8'd255, 8'd0, 8'd0, 8'd255, 1'b1}, 1'b0, '0},
		'{'{8'hAA, 8'h55, 8'h55, 8'hAA, 1'b0}, 1'b0, '0},
		'{'{8'd1, 8'd128, 8'd254, 8'd128, 1'b1}, 1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic wr_en;
	logic [INDEX_W-1:0] wr_index;
	logic [COEF_W-1:0] wr_data;

	y2r_pix_if pix_ch ();
	y2r_rgb_if rgb_ch ();

	yuyv_to_rgb24_converter #(.COEF_FRAC_BITS(FRAC)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.pix      (pix_ch),
		.rgb      (rgb_ch)
	);

	coef_t       gains;
	pixel_pair_t pending_pairs[$];
	logic        cur_typed;
	pixel_pair_t cur_want;
	bit          steady;
	int          stall_left;
	int          quiet_cycles;
	int          errors;
	int          n_sent;
	int          n_checked;
	int          n_settings;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Floor a Q16 sum to its integer part and clamp it to one byte.
	function automatic logic [BYTE_W-1:0] clamp_channel(longint acc);
		longint whole;
		if (acc < 0) begin
			return '0;
		end
		whole = acc >>> FRAC;
		return (whole > 255) ? CHAN_MAX : whole[BYTE_W-1:0];
	endfunction

	function automatic rgb_t convert_pixel(logic [BYTE_W-1:0] y, longint du, longint dv,
		coef_t g);
		longint base;
		rgb_t   px;
		base = longint'(y) <<< FRAC;
		px.red   = clamp_channel(base + longint'(g.v_to_red) * dv);
		px.green = clamp_channel(base - longint'(g.v_to_green) * dv
			- longint'(g.u_to_green) * du);
		px.blue  = clamp_channel(base + longint'(g.u_to_blue) * du);
		return px;
	endfunction

	function automatic pixel_pair_t convert_macropixel(macropixel_t m, coef_t g);
		longint      du;
		longint      dv;
		pixel_pair_t p;
		du = longint'(m.u) - longint'(CHROMA_OFFSET);
		dv = longint'(m.v) - longint'(CHROMA_OFFSET);
		p.first  = convert_pixel(m.y0, du, dv, g);
		p.second = convert_pixel(m.y1, du, dv, g);
		p.done   = m.eof;
		return p;
	endfunction

	// Random macropixels, weighted toward the neutral point and the byte extremes.
	function automatic macropixel_t random_macropixel();
		macropixel_t m;
		int          kind;
		kind  = $urandom_range(0, 9);
		m.y0  = BYTE_W'($urandom_range(0, 255));
		m.u   = BYTE_W'($urandom_range(0, 255));
		m.y1  = BYTE_W'($urandom_range(0, 255));
		m.v   = BYTE_W'($urandom_range(0, 255));
		m.eof = ($urandom_range(0, 15) == 0);
		case (kind)
			6: begin
				m.u = BYTE_W'($urandom_range(126, 130));
				m.v = BYTE_W'($urandom_range(126, 130));
			end
			7: begin
				m.y0 = $urandom_range(0, 1) ? CHAN_MAX : '0;
				m.y1 = $urandom_range(0, 1) ? CHAN_MAX : '0;
			end
			8: begin
				m.u = $urandom_range(0, 1) ? CHAN_MAX : '0;
				m.v = $urandom_range(0, 1) ? CHAN_MAX : '0;
			end
			9: m.eof = 1'b1;
			default: ;
		endcase
		return m;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 65) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 20);
	endfunction

	function automatic coef_t gains_for(gain_set_t s);
		coef_t g;
		case (s)
			GAINS_MAX:  g = '{GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX};
			GAINS_ZERO: g = '0;
			GAINS_RANDOM: begin
				g.v_to_red   = COEF_W'($urandom_range(0, 131071));
				g.v_to_green = COEF_W'($urandom_range(0, 131071));
				g.u_to_green = COEF_W'($urandom_range(0, 131071));
				g.u_to_blue  = COEF_W'($urandom_range(0, 131071));
			end
			GAINS_MIXED: begin
				g.v_to_red   = '0;
				g.v_to_green = GAIN_MAX;
				g.u_to_green = COEF_W'($urandom_range(0, 131071));
				g.u_to_blue  = GAIN_MAX;
			end
			default: g = GAINS_DEFAULT;
		endcase
		return g;
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		errors++;
	endtask

	// One pair as text: both pixels and the frame mark.
	function automatic string pair_text(pixel_pair_t p);
		return $sformatf("%0d,%0d,%0d / %0d,%0d,%0d eof %0b",
			p.first.red, p.first.green, p.first.blue,
			p.second.red, p.second.green, p.second.blue, p.done);
	endfunction

	task automatic check_pair(pixel_pair_t got, pixel_pair_t want);
		if (got !== want) begin
			report_mismatch($sformatf("pair %0d: got %s, want %s",
				n_checked, pair_text(got), pair_text(want)));
		end
	endtask

	// Present one macropixel from a falling edge and hold it until the transfer.
	task automatic send_macropixel(macropixel_t m, logic typed, pixel_pair_t want);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			pix_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_ch.luma_first   = m.y0;
		pix_ch.chroma_blue  = m.u;
		pix_ch.luma_second  = m.y1;
		pix_ch.chroma_red   = m.v;
		pix_ch.end_of_frame = m.eof;
		cur_typed           = typed;
		cur_want            = want;
		pix_ch.valid        = 1'b1;
		do begin
			@(posedge clk);
		end while (!pix_ch.ready);
		@(negedge clk);
	endtask

	// Stop the input, let every pair come out, then let the pipeline empty.
	task automatic settle();
		pix_ch.valid = 1'b0;
		while (pending_pairs.size() != 0) begin
			@(negedge clk);
		end
		repeat (PIPE_LAT + 2) @(negedge clk);
	endtask

	task automatic write_gain(logic [INDEX_W-1:0] idx, logic [COEF_W-1:0] val);
		wr_en    = 1'b1;
		wr_index = idx;
		wr_data  = val;
		case (idx)
			REG_V_TO_RED:   gains.v_to_red   = val;
			REG_V_TO_GREEN: gains.v_to_green = val;
			REG_U_TO_GREEN: gains.u_to_green = val;
			REG_U_TO_BLUE:  gains.u_to_blue  = val;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic load_gains(coef_t g);
		write_gain(REG_V_TO_RED, g.v_to_red);
		write_gain(REG_V_TO_GREEN, g.v_to_green);
		write_gain(REG_U_TO_GREEN, g.u_to_green);
		write_gain(REG_U_TO_BLUE, g.u_to_blue);
		wr_en = 1'b0;
	endtask

	// The first stretch of each setting runs at full rate on both sides.
	task automatic run_random(int count);
		for (int i = 0; i < count; i++) begin
			steady = (i < 20);
			send_macropixel(random_macropixel(), 1'b0, '0);
		end
		steady = 1'b0;
	endtask

	task automatic run_setting(gain_set_t s);
		settle();
		load_gains(gains_for(s));
		n_settings++;
		run_random(RANDOM_PER_SET);
	endtask

	// Receiver readiness: mostly ready, short stalls, now and then a long one.
	always @(negedge clk) begin
		int r;
		r = $urandom_range(0, 99);
		if (steady) begin
			rgb_ch.ready = 1'b1;
		end else if (stall_left > 0) begin
			rgb_ch.ready = 1'b0;
			stall_left--;
		end else if (r < 70) begin
			rgb_ch.ready = 1'b1;
		end else if (r < 93) begin
			rgb_ch.ready = 1'b0;
			stall_left   = $urandom_range(0, 2);
		end else begin
			rgb_ch.ready = 1'b0;
			stall_left   = $urandom_range(8, 20);
		end
	end

	// Record expectations on input transfers and check output transfers.
	always @(posedge clk) begin
		pixel_pair_t got;
		macropixel_t m;
		bit          moved;
		if (arst_n) begin
			moved = 1'b0;
			if (pix_ch.valid && pix_ch.ready) begin
				m = '{pix_ch.luma_first, pix_ch.chroma_blue, pix_ch.luma_second,
					pix_ch.chroma_red, pix_ch.end_of_frame};
				pending_pairs.push_back(cur_typed ? cur_want : convert_macropixel(m, gains));
				n_sent++;
				moved = 1'b1;
			end
			if (rgb_ch.valid && rgb_ch.ready) begin
				got.first  = '{rgb_ch.red_first, rgb_ch.green_first, rgb_ch.blue_first};
				got.second = '{rgb_ch.red_second, rgb_ch.green_second, rgb_ch.blue_second};
				got.done   = rgb_ch.frame_done;
				if (pending_pairs.size() == 0) begin
					report_mismatch("output transfer with no pair expected");
				end else begin
					check_pair(got, pending_pairs.pop_front());
				end
				n_checked++;
				moved = 1'b1;
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
				$display("[yuyv_to_rgb24_converter] ERROR");
				$finish;
			end
		end
	end

	initial begin
		arst_n              = 1'b0;
		wr_en               = 1'b0;
		wr_index            = REG_V_TO_RED;
		wr_data             = '0;
		pix_ch.valid        = 1'b0;
		pix_ch.luma_first   = '0;
		pix_ch.chroma_blue  = '0;
		pix_ch.luma_second  = '0;
		pix_ch.chroma_red   = '0;
		pix_ch.end_of_frame = 1'b0;
		rgb_ch.ready        = 1'b0;
		cur_typed           = 1'b0;
		cur_want            = '0;
		steady              = 1'b0;
		stall_left          = 0;
		quiet_cycles        = 0;
		errors              = 0;
		n_sent              = 0;
		n_checked           = 0;
		n_settings          = 1;
		gains               = GAINS_DEFAULT;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// Directed rows run on the gains loaded by reset.
		for (int i = 0; i < N_DIRECTED; i++) begin
			send_macropixel(DIRECTED[i].px, DIRECTED[i].typed, DIRECTED[i].want);
		end
		run_random(RANDOM_PER_SET);

		run_setting(GAINS_MAX);
		run_setting(GAINS_ZERO);
		run_setting(GAINS_RANDOM);
		run_setting(GAINS_MIXED);
		run_setting(GAINS_RESTORE);

		settle();
		if (pending_pairs.size() != 0) begin
			report_mismatch($sformatf("%0d expected pairs never arrived",
				pending_pairs.size()));
		end
		$display("Sent %0d macropixels and checked %0d pixel pairs", n_sent, n_checked);
		$display("across %0d gain settings, including all-zero and all-maximum gains.",
			n_settings);
		if (errors == 0) begin
			$display("[yuyv_to_rgb24_converter] OK");
		end else begin
			$display("[yuyv_to_rgb24_converter] ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
